/* hw/rtl/vcc_pkg.sv */
// shared types and constants for the vertex color converter
// no dependencies

package vcc_pkg;

    localparam int ChanCount = 4;
    localparam int RegCount  = 8;

    // channel slots inside the pipeline
    localparam int CH_ALPHA = 0;
    localparam int CH_RED   = 1;
    localparam int CH_GREEN = 2;
    localparam int CH_BLUE  = 3;

    localparam logic [31:0] FLOAT_ONE = 32'h3f80_0000;

    typedef enum logic [1:0] {
        FUNC_SWAP   = 2'd0,
        FUNC_FLOAT  = 2'd1,
        FUNC_FACE   = 2'd2,
        FUNC_OFFSET = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        REG_FACE_ALPHA   = 4'd0,
        REG_FACE_RED     = 4'd1,
        REG_FACE_GREEN   = 4'd2,
        REG_FACE_BLUE    = 4'd3,
        REG_OFFSET_ALPHA = 4'd4,
        REG_OFFSET_RED   = 4'd5,
        REG_OFFSET_GREEN = 4'd6,
        REG_OFFSET_BLUE  = 4'd7
    } reg_idx_t;

    // channel outcome known so far
    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_FULL = 2'd1,
        CLS_NUM  = 2'd2
    } cls_t;

    // leading zero count of a nonzero 48-bit word
    function automatic logic [5:0] lzc48(input logic [47:0] w);
        logic [5:0] n;
        logic       found;
        n     = 6'd0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && w[i]) begin
                n     = 6'(47 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

/* hw/rtl/vertex_color_converter.sv */
// vertex color converter top level: float or packed color to abgr8888
// depends on vcc_pkg

// Usage:
// - input channel s_*: one beat per vertex color, s_func selects the mode
//   (packed byte swap, four floats, intensity times face or offset color)
// - result channel m_*: one packed color per input beat, in order
// - cfg_*: write port for the eight face and offset float registers;
//   write only while no beat is in flight, indexes above seven are dropped
// - pipeline: four register stages; an accepted beat passes stage 1, stage 2,
//   stage 3 and the output register before m_valid rises
// - throughput: one beat per cycle while m_ready does not hold the pipeline;
//   the stages are the per-channel float multiply, normalize, round and scale-by-255
// - reset: aresetn low clears the pipeline valid bits and the registers
//   (all colors read as +0.0)
// - stall: when m_ready is low with a result pending the whole pipeline
//   holds and s_ready drops, nothing is lost or repeated

module vertex_color_converter
    import vcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [31:0] s_word0,
    input  logic [31:0] s_word1,
    input  logic [31:0] s_word2,
    input  logic [31:0] s_word3,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_packed_color,

    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] face_reg   [ChanCount];
    logic [31:0] offset_reg [ChanCount];

    logic adv;

    // stage 1: classify and multiply mantissas
    logic        v1_reg;
    logic        swap1_reg;
    logic [31:0] raw1_reg;
    cls_t        cls1_reg [ChanCount];
    logic [47:0] q1_reg   [ChanCount];
    logic [8:0]  es1_reg  [ChanCount];
    cls_t        cls1_next [ChanCount];
    logic [47:0] q1_next   [ChanCount];
    logic [8:0]  es1_next  [ChanCount];

    // stage 2: normalized product and exponent
    logic        v2_reg;
    logic        swap2_reg;
    logic [31:0] raw2_reg;
    cls_t        cls2_reg [ChanCount];
    logic [47:0] qn2_reg  [ChanCount];
    logic [10:0] x2_reg   [ChanCount];
    logic [47:0] qn2_next [ChanCount];
    logic [10:0] x2_next  [ChanCount];

    // stage 3: rounded single and clamp decision
    logic        v3_reg;
    logic        swap3_reg;
    logic [31:0] raw3_reg;
    cls_t        cls3_reg  [ChanCount];
    logic [23:0] mant3_reg [ChanCount];
    logic [3:0]  sh3_reg   [ChanCount];
    cls_t        cls3_next  [ChanCount];
    logic [23:0] mant3_next [ChanCount];
    logic [3:0]  sh3_next   [ChanCount];

    // stage 4: scale by 255 and pack
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [7:0]  byte_next [ChanCount];
    logic [31:0] out_data_next;

    assign adv            = !out_valid_reg || m_ready;
    assign s_ready        = adv;
    assign m_valid        = out_valid_reg;
    assign m_packed_color = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < ChanCount; c++) begin
                face_reg[c]   <= '0;
                offset_reg[c] <= '0;
            end
        end else if (cfg_wr_en && cfg_index < 4'(RegCount)) begin
            if (cfg_index < 4'(ChanCount)) begin
                face_reg[cfg_index[1:0]] <= cfg_data;
            end else begin
                offset_reg[cfg_index[1:0]] <= cfg_data;
            end
        end
    end

    always_comb begin
        logic [31:0] a;
        logic [31:0] b;
        logic        a_zero, a_inf, a_nan, b_zero, b_inf, b_nan;
        logic [23:0] ma, mb;
        logic [7:0]  ea, eb;
        for (int c = 0; c < ChanCount; c++) begin
            a = s_word0;
            b = FLOAT_ONE;
            case (func_t'(s_func))
                FUNC_FLOAT: begin
                    case (c)
                        CH_RED:   a = s_word1;
                        CH_GREEN: a = s_word2;
                        CH_BLUE:  a = s_word3;
                        default:  a = s_word0;
                    endcase
                end
                FUNC_FACE:   b = face_reg[c];
                FUNC_OFFSET: b = offset_reg[c];
                default:     b = FLOAT_ONE;
            endcase
            a_zero = a[30:23] == 8'd0 && a[22:0] == 23'd0;
            a_inf  = a[30:23] == 8'hff && a[22:0] == 23'd0;
            a_nan  = a[30:23] == 8'hff && a[22:0] != 23'd0;
            b_zero = b[30:23] == 8'd0 && b[22:0] == 23'd0;
            b_inf  = b[30:23] == 8'hff && b[22:0] == 23'd0;
            b_nan  = b[30:23] == 8'hff && b[22:0] != 23'd0;
            ma     = {a[30:23] != 8'd0, a[22:0]};
            mb     = {b[30:23] != 8'd0, b[22:0]};
            // subnormals use exponent one
            ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
            eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
            if (a_nan || b_nan || a_zero || b_zero || (a[31] ^ b[31])) begin
                cls1_next[c] = CLS_ZERO;
            end else if (a_inf || b_inf) begin
                cls1_next[c] = CLS_FULL;
            end else begin
                cls1_next[c] = CLS_NUM;
            end
            q1_next[c]  = 48'(ma) * 48'(mb);
            es1_next[c] = 9'(ea) + 9'(eb);
        end
    end

    always_comb begin
        logic [5:0] lz;
        for (int c = 0; c < ChanCount; c++) begin
            lz          = lzc48(q1_reg[c]);
            qn2_next[c] = q1_reg[c] << lz;
            // unbiased exponent of the leading one
            x2_next[c]  = {2'b00, es1_reg[c]} - {5'b0, lz} - 11'd253;
        end
    end

    always_comb begin
        logic [23:0] mr;
        logic        inc;
        logic [24:0] sum;
        logic [10:0] xr;
        for (int c = 0; c < ChanCount; c++) begin
            mr  = qn2_reg[c][47:24];
            inc = qn2_reg[c][23] && ((|qn2_reg[c][22:0]) || mr[0]);
            sum = {1'b0, mr} + 25'(inc);
            if (sum[24]) begin
                mant3_next[c] = 24'h80_0000;
                xr            = x2_reg[c] + 11'd1;
            end else begin
                mant3_next[c] = sum[23:0];
                xr            = x2_reg[c];
            end
            sh3_next[c]  = 4'((~xr) + 11'd1);
            cls3_next[c] = cls2_reg[c];
            if (cls2_reg[c] == CLS_NUM) begin
                if (!xr[10]) begin
                    cls3_next[c] = CLS_FULL;
                end else if ($signed(xr) < -11'sd9) begin
                    // below 2^-9 the scaled value stays under one
                    cls3_next[c] = CLS_ZERO;
                end
            end
        end
    end

    always_comb begin
        logic [31:0] p;
        logic [24:0] s8, s7;
        logic [32:0] pr;
        logic [32:0] iv;
        for (int c = 0; c < ChanCount; c++) begin
            p  = 32'(mant3_reg[c]) * 32'd255;
            s8 = {1'b0, p[31:8]} + 25'(p[7] && ((|p[6:0]) || p[8]));
            s7 = {1'b0, p[30:7]} + 25'(p[6] && ((|p[5:0]) || p[7]));
            pr = p[31] ? {s8, 8'b0} : {1'b0, s7, 7'b0};
            iv = pr >> (6'd23 + 6'(sh3_reg[c]));
            case (cls3_reg[c])
                CLS_FULL: byte_next[c] = 8'hff;
                CLS_NUM:  byte_next[c] = (iv[8:0] >= 9'd255) ? 8'hff : iv[7:0];
                default:  byte_next[c] = 8'h00;
            endcase
        end
        if (swap3_reg) begin
            out_data_next = {raw3_reg[31:24], raw3_reg[7:0], raw3_reg[15:8],
                             raw3_reg[23:16]};
        end else begin
            out_data_next = {byte_next[CH_ALPHA], byte_next[CH_BLUE],
                             byte_next[CH_GREEN], byte_next[CH_RED]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= s_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            swap1_reg    <= func_t'(s_func) == FUNC_SWAP;
            raw1_reg     <= s_word0;
            swap2_reg    <= swap1_reg;
            raw2_reg     <= raw1_reg;
            swap3_reg    <= swap2_reg;
            raw3_reg     <= raw2_reg;
            out_data_reg <= out_data_next;
            for (int c = 0; c < ChanCount; c++) begin
                cls1_reg[c]  <= cls1_next[c];
                q1_reg[c]    <= q1_next[c];
                es1_reg[c]   <= es1_next[c];
                cls2_reg[c]  <= cls1_reg[c];
                qn2_reg[c]   <= qn2_next[c];
                x2_reg[c]    <= x2_next[c];
                cls3_reg[c]  <= cls3_next[c];
                mant3_reg[c] <= mant3_next[c];
                sh3_reg[c]   <= sh3_next[c];
            end
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for vertex_color_converter: all four color modes
// with random stalls; depends on vcc_pkg and the converter rtl

module tb;
    import vcc_pkg::*;

    localparam logic [31:0] QNAN       = 32'h7fc0_0000;
    localparam logic [31:0] POS_INF    = 32'h7f80_0000;
    localparam logic [31:0] NEG_INF    = 32'hff80_0000;
    localparam logic [31:0] NEG_ZERO   = 32'h8000_0000;
    localparam logic [31:0] MAX_FLOAT  = 32'h7f7f_ffff;
    localparam logic [31:0] MIN_SUBN   = 32'h0000_0001;
    localparam logic [31:0] FLOAT_HALF = 32'h3f00_0000;
    localparam logic [31:0] FLOAT_TWO  = 32'h4000_0000;
    localparam logic [31:0] FLOAT_255  = 32'h437f_0000;
    localparam int          PIPE_DRAIN = 8;
    localparam int          STALL_LIMIT = 3000;

    typedef struct packed {
        func_t       func;
        logic [31:0] word0;
        logic [31:0] word1;
        logic [31:0] word2;
        logic [31:0] word3;
    } vtx_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = FUNC_SWAP;
    logic [31:0] s_word0 = '0;
    logic [31:0] s_word1 = '0;
    logic [31:0] s_word2 = '0;
    logic [31:0] s_word3 = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_packed_color;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    vtx_t        vtx_pending_q[$];
    logic [31:0] color_expected_q[$];
    logic [31:0] color_regs[RegCount];
    vtx_t        vtx_on_bus;
    int          cycle_cnt = 0;
    int          stall_cnt = 0;
    int          hold_cnt = 0;
    bit          held_once = 1'b0;
    int          colors_seen = 0;
    int          mismatches = 0;
    int          mode_cnt[4] = '{0, 0, 0, 0};

    vertex_color_converter uut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // single precision multiply, round to nearest even, with subnormals
    function automatic logic [31:0] fmul32(logic [31:0] a, logic [31:0] b);
        logic        sgn;
        logic [47:0] prod;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        int          lead;
        int          er;
        int          sh;
        sgn = a[31] ^ b[31];
        if ((a[30:23] == 8'hff && a[22:0] != 0) || (b[30:23] == 8'hff && b[22:0] != 0))
            return QNAN;
        if (a[30:23] == 8'hff || b[30:23] == 8'hff) begin
            if (a[30:0] == 0 || b[30:0] == 0)
                return QNAN;
            return {sgn, POS_INF[30:0]};
        end
        if (a[30:0] == 0 || b[30:0] == 0)
            return {sgn, 31'd0};
        prod = 48'({a[30:23] != 0, a[22:0]}) * 48'({b[30:23] != 0, b[22:0]});
        lead = 0;
        for (int i = 0; i < 48; i++)
            if (prod[i])
                lead = i;
        er = (a[30:23] == 0 ? 1 : int'(a[30:23])) + (b[30:23] == 0 ? 1 : int'(b[30:23]))
             - 127 + (lead - 46);
        sh = lead - 23;
        if (er < 1)
            sh = sh + (1 - er);
        if (sh <= 0) begin
            mant = 64'(prod) << (-sh);
        end else if (sh >= 49) begin
            mant = '0;
        end else begin
            mant = 64'(prod) >> sh;
            rem  = 64'(prod) & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && mant[0]))
                mant = mant + 1;
        end
        if (er < 1)
            return {sgn, 31'(mant)};
        if (mant == (64'd1 << 24)) begin
            mant = mant >> 1;
            er   = er + 1;
        end
        if (er >= 255)
            return {sgn, POS_INF[30:0]};
        return {sgn, 8'(er), mant[22:0]};
    endfunction

    // clamp to 0..1, scale by 255, truncate
    function automatic logic [7:0] chan_to_byte(logic [31:0] v);
        logic [31:0] s;
        if (v[30:23] == 8'hff && v[22:0] != 0)
            return 8'd0;
        if (v[31] || v[30:0] == 0)
            return 8'd0;
        if (v[30:0] >= FLOAT_ONE[30:0])
            return 8'd255;
        s = fmul32(v, FLOAT_255);
        if (s[30:0] >= FLOAT_255[30:0])
            return 8'd255;
        if (s[30:23] < 8'd127)
            return 8'd0;
        return 8'({1'b1, s[22:0]} >> (150 - int'(s[30:23])));
    endfunction

    function automatic logic [31:0] pack_abgr(logic [31:0] a, logic [31:0] r,
                                              logic [31:0] g, logic [31:0] b);
        return {chan_to_byte(a), chan_to_byte(b), chan_to_byte(g), chan_to_byte(r)};
    endfunction

    function automatic logic [31:0] abgr_of(vtx_t v);
        int base;
        case (v.func)
            FUNC_SWAP:
                return {v.word0[31:24], v.word0[7:0], v.word0[15:8], v.word0[23:16]};
            FUNC_FLOAT:
                return pack_abgr(v.word0, v.word1, v.word2, v.word3);
            default: begin
                base = (v.func == FUNC_FACE) ? REG_FACE_ALPHA : REG_OFFSET_ALPHA;
                return pack_abgr(fmul32(v.word0, color_regs[base + CH_ALPHA]),
                                 fmul32(v.word0, color_regs[base + CH_RED]),
                                 fmul32(v.word0, color_regs[base + CH_GREEN]),
                                 fmul32(v.word0, color_regs[base + CH_BLUE]));
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_float();
        logic [31:0] specials[8];
        specials = '{QNAN, POS_INF, NEG_INF, NEG_ZERO, MAX_FLOAT, MIN_SUBN, 32'h0, 32'hffff_ffff};
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2, 3, 4: return {1'b0, 8'($urandom_range(100, 126)), 23'($urandom)};
            5: return {1'b0, 8'($urandom_range(118, 126)), 23'($urandom_range(0, 15))};
            6: return FLOAT_ONE + 32'($signed(3'($urandom_range(0, 4))) - 2);
            7: return specials[$urandom_range(0, 7)];
            8: return {1'b0, 8'($urandom_range(127, 129)), 23'($urandom)};
            default: return {1'b1, 8'($urandom_range(100, 130)), 23'($urandom)};
        endcase
    endfunction

    function automatic vtx_t rand_vtx();
        vtx_t v;
        v.func  = func_t'($urandom_range(0, 3));
        v.word0 = (v.func == FUNC_SWAP) ? $urandom : rand_float();
        v.word1 = $urandom_range(0, 1) ? rand_float() : $urandom;
        v.word2 = $urandom_range(0, 1) ? rand_float() : $urandom;
        v.word3 = $urandom_range(0, 1) ? rand_float() : $urandom;
        return v;
    endfunction

    // no idling inside the quiet window
    function automatic bit idle_now();
        if (cycle_cnt > 700 && cycle_cnt < 950)
            return 1'b0;
        return $urandom_range(0, 99) < 9;
    endfunction

    // sender
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                color_expected_q.push_back(abgr_of(vtx_on_bus));
                mode_cnt[vtx_on_bus.func]++;
            end
            if (!s_valid || s_ready) begin
                if (vtx_pending_q.size() > 0 && !idle_now()) begin
                    vtx_on_bus = vtx_pending_q.pop_front();
                    s_valid <= 1'b1;
                    s_func  <= vtx_on_bus.func;
                    s_word0 <= vtx_on_bus.word0;
                    s_word1 <= vtx_on_bus.word1;
                    s_word2 <= vtx_on_bus.word2;
                    s_word3 <= vtx_on_bus.word3;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                colors_seen++;
                if (color_expected_q.size() == 0) begin
                    $error("packed_color beat with nothing expected: %h", m_packed_color);
                    mismatches++;
                end else if (m_packed_color !== color_expected_q[0]) begin
                    $error("packed_color expected %h actual %h",
                           color_expected_q[0], m_packed_color);
                    mismatches++;
                    void'(color_expected_q.pop_front());
                end else begin
                    void'(color_expected_q.pop_front());
                end
            end
            // one long hold-off so the pipeline backs up into s_ready
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready  <= 1'b0;
            end else if (!held_once && colors_seen >= 300) begin
                held_once <= 1'b1;
                hold_cnt  <= 80;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= !idle_now();
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("[vertex_color_converter] ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (vtx_pending_q.size() > 0 || s_valid || color_expected_q.size() > 0)
            @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    // writes all eight color registers plus one out-of-range index
    task automatic load_colors(logic [31:0] vals[RegCount]);
        for (int i = 0; i <= RegCount; i++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            if (i < RegCount) begin
                cfg_index <= 4'(i);
                cfg_data  <= vals[i];
                color_regs[i] = vals[i];
            end else begin
                cfg_index <= 4'($urandom_range(RegCount, 15));
                cfg_data  <= $urandom;
            end
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_vtx(func_t f, logic [31:0] w0, logic [31:0] w1,
                            logic [31:0] w2, logic [31:0] w3);
        vtx_pending_q.push_back('{f, w0, w1, w2, w3});
    endtask

    initial begin
        logic [31:0] vals[RegCount];
        for (int i = 0; i < RegCount; i++)
            color_regs[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        vals = '{FLOAT_ONE, FLOAT_HALF, POS_INF, QNAN,
                 32'hbf80_0000, MAX_FLOAT, 32'h0, MIN_SUBN};
        load_colors(vals);
        push_vtx(FUNC_SWAP, 32'h0, 32'h0, 32'h0, 32'h0);
        push_vtx(FUNC_SWAP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        push_vtx(FUNC_SWAP, 32'h1234_5678, 32'h0, 32'h0, 32'h0);
        push_vtx(FUNC_FLOAT, FLOAT_ONE, FLOAT_ONE, FLOAT_ONE, FLOAT_ONE);
        push_vtx(FUNC_FLOAT, 32'h0, NEG_ZERO, QNAN, 32'hffff_ffff);
        push_vtx(FUNC_FLOAT, POS_INF, NEG_INF, FLOAT_TWO, MAX_FLOAT);
        push_vtx(FUNC_FLOAT, MIN_SUBN, FLOAT_HALF, 32'h3f7f_ffff, 32'h3b80_8081);
        push_vtx(FUNC_FLOAT, 32'h3c00_0000, 32'hbf00_0000, 32'h3e80_0000, 32'h3f80_0001);
        push_vtx(FUNC_FACE, FLOAT_ONE, 32'h0, 32'h0, 32'h0);
        push_vtx(FUNC_FACE, POS_INF, 32'h0, 32'h0, 32'h0);
        push_vtx(FUNC_FACE, 32'h0, $urandom, $urandom, $urandom);
        push_vtx(FUNC_FACE, FLOAT_TWO, 32'h0, 32'h0, 32'h0);
        push_vtx(FUNC_FACE, QNAN, 32'h0, 32'h0, 32'h0);
        push_vtx(FUNC_OFFSET, FLOAT_ONE, 32'h0, 32'h0, 32'h0);
        push_vtx(FUNC_OFFSET, 32'hbf80_0000, 32'h0, 32'h0, 32'h0);
        push_vtx(FUNC_OFFSET, MAX_FLOAT, 32'h0, 32'h0, 32'h0);
        push_vtx(FUNC_OFFSET, POS_INF, 32'h0, 32'h0, 32'h0);
        push_vtx(FUNC_OFFSET, 32'h4b00_0000, 32'h0, 32'h0, 32'h0);
        push_vtx(FUNC_OFFSET, NEG_ZERO, 32'h0, 32'h0, 32'h0);
        wait_drained();

        // random phases, the last one with extreme register values
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 3)
                vals = '{32'hffff_ffff, POS_INF, MIN_SUBN, FLOAT_ONE,
                         NEG_ZERO, MAX_FLOAT, NEG_INF, 32'h0};
            else
                for (int i = 0; i < RegCount; i++)
                    vals[i] = rand_float();
            load_colors(vals);
            for (int n = 0; n < 210; n++)
                vtx_pending_q.push_back(rand_vtx());
            wait_drained();
        end

        $display("covered %0d swap, %0d float, %0d face, %0d offset colors",
                 mode_cnt[FUNC_SWAP], mode_cnt[FUNC_FLOAT],
                 mode_cnt[FUNC_FACE], mode_cnt[FUNC_OFFSET]);
        $display("five register settings, one long result-side hold-off, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("[vertex_color_converter] OK");
        else
            $display("[vertex_color_converter] ERROR");
        $finish;
    end

endmodule
